// File: hdl/fswt_pkg.sv
`default_nettype none

package fswt_pkg;

  localparam int MAX_FRAME_BYTES = 16;
  localparam int IDX_W           = $clog2(MAX_FRAME_BYTES);
  localparam int LEN_W           = 5;
  localparam int PHASE_W         = 4;

  localparam logic [LEN_W-1:0]   LEN_RESET  = 5'd4;
  localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(MAX_FRAME_BYTES);
  localparam logic [PHASE_W-1:0] START_PHASE = 4'd0;
  localparam logic [PHASE_W-1:0] STOP_PHASE  = 4'd9;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  // buffer access issued by the control logic
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic line_level;
    logic accepted;
    logic busy_res;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/fswt_frame_mem.sv
`default_nettype none

module fswt_frame_mem (
  input  wire logic               clk,
  input  wire fswt_pkg::mem_req_t req,
  output logic [7:0]              rdata
);

  logic [7:0] mem [fswt_pkg::MAX_FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read data register doubles as the byte being sent; write-first on a collision
  always_ff @(posedge clk) begin
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr)) begin
        rdata <= req.wdata;
      end else begin
        rdata <= mem[req.raddr];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/fswt_ctrl.sv
`default_nettype none

module fswt_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [fswt_pkg::LEN_W-1:0] cfg_data,
  input  wire logic                      take,
  input  wire logic                      action,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      link_ready,
  input  wire logic [7:0]                shift_byte,
  output fswt_pkg::mem_req_t             mem_req,
  output fswt_pkg::result_t              result
);

  logic [fswt_pkg::LEN_W-1:0]   frame_length;
  logic [fswt_pkg::IDX_W-1:0]   byte_index, byte_index_next;
  logic [fswt_pkg::PHASE_W-1:0] bit_phase, bit_phase_next;
  logic                         transmitting, transmitting_next;
  logic                         wire_level, wire_level_next;

  logic [fswt_pkg::LEN_W-1:0]   len_eff;
  logic                         last_byte;
  logic [fswt_pkg::PHASE_W-1:0] phase_m1;
  logic                         acc;

  always_comb begin
    if (frame_length == '0) begin
      len_eff = fswt_pkg::LEN_W'(1);
    end else if (frame_length > fswt_pkg::LEN_MAX) begin
      len_eff = fswt_pkg::LEN_MAX;
    end else begin
      len_eff = frame_length;
    end
  end

  assign last_byte = (fswt_pkg::LEN_W'(byte_index) + fswt_pkg::LEN_W'(1)) >= len_eff;
  assign phase_m1  = bit_phase - fswt_pkg::PHASE_W'(1);

  always_comb begin
    byte_index_next   = byte_index;
    bit_phase_next    = bit_phase;
    transmitting_next = transmitting;
    wire_level_next   = wire_level;
    acc               = 1'b0;
    mem_req           = '0;

    if (take) begin
      if (action == fswt_pkg::ACT_LOAD) begin
        if (!transmitting) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = byte_index;
          mem_req.wdata = data_byte;
          acc           = 1'b1;
          if (last_byte) begin
            byte_index_next   = '0;
            bit_phase_next    = fswt_pkg::START_PHASE;
            transmitting_next = 1'b1;
            mem_req.re        = 1'b1;
            mem_req.raddr     = '0;
          end else begin
            byte_index_next = byte_index + fswt_pkg::IDX_W'(1);
          end
        end
      end else if (link_ready && transmitting) begin
        if (bit_phase == fswt_pkg::START_PHASE) begin
          wire_level_next = 1'b0;
          bit_phase_next  = fswt_pkg::PHASE_W'(1);
        end else if (bit_phase < fswt_pkg::STOP_PHASE) begin
          wire_level_next = shift_byte[phase_m1[2:0]];
          bit_phase_next  = bit_phase + fswt_pkg::PHASE_W'(1);
        end else begin
          wire_level_next = 1'b1;
          bit_phase_next  = fswt_pkg::START_PHASE;
          if (last_byte) begin
            transmitting_next = 1'b0;
            byte_index_next   = '0;
          end else begin
            // next byte lands in the read register before its first data bit
            byte_index_next = byte_index + fswt_pkg::IDX_W'(1);
            mem_req.re      = 1'b1;
            mem_req.raddr   = byte_index + fswt_pkg::IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= fswt_pkg::LEN_RESET;
    end else if (cfg_we) begin
      frame_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      bit_phase    <= fswt_pkg::START_PHASE;
      transmitting <= 1'b0;
      wire_level   <= 1'b1;
    end else begin
      byte_index   <= byte_index_next;
      bit_phase    <= bit_phase_next;
      transmitting <= transmitting_next;
      wire_level   <= wire_level_next;
    end
  end

  assign result.line_level = wire_level_next;
  assign result.accepted   = acc;
  assign result.busy_res   = transmitting_next;

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    bit_phase <= fswt_pkg::STOP_PHASE)
    else $error("bit phase beyond stop bit");

  a_idle_line_high: assert property (@(posedge clk) disable iff (rst)
    !transmitting |-> (wire_level && (bit_phase == fswt_pkg::START_PHASE)))
    else $error("idle with line low or phase not at start");

  a_no_write_while_sending: assert property (@(posedge clk) disable iff (rst)
    transmitting |-> !mem_req.we)
    else $error("buffer written during a frame");

  a_frame_start_reads_first: assert property (@(posedge clk) disable iff (rst)
    (!transmitting && transmitting_next) |-> (mem_req.re && (mem_req.raddr == '0)))
    else $error("frame started without fetching the first byte");

endmodule

`default_nettype wire

// File: hdl/fswt_out_buf.sv
`default_nettype none

module fswt_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire fswt_pkg::result_t res_in,
  output logic                   full,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output fswt_pkg::result_t      res_out
);

  logic              skid_valid;
  fswt_pkg::result_t skid;
  logic              out_free;

  assign out_free = !res_valid || !res_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        res_valid  <= skid_valid || take;
        skid_valid <= 1'b0;
      end else if (take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        res_out <= skid;
      end else if (take) begin
        res_out <= res_in;
      end
    end else if (take) begin
      skid <= res_in;
    end
  end

endmodule

`default_nettype wire

// File: hdl/framed_single_wire_transmitter_unit.sv
// Results are registered in the output buffer before they are presented.
// Throughput: one transaction per cycle while item_stall is low; each load or tick is one
// state update plus at most one buffer write and one buffer read; the read register holds
// the byte on the wire. A two-entry output buffer takes one more transaction while a result
// is stalled, then the input stalls until the output moves again.
// Reset (rst, synchronous): line high, not sending, collect position zero, frame length 4.
`default_nettype none

module framed_single_wire_transmitter_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [fswt_pkg::LEN_W-1:0]  cfg_data,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic                        action,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        link_ready,
  output logic                             res_valid,
  input  wire logic                        res_stall,
  output logic                             line_level,
  output logic                             accepted,
  output logic                             busy_res
);

  logic               take;
  logic               full;
  logic [7:0]         shift_byte;
  fswt_pkg::mem_req_t mem_req;
  fswt_pkg::result_t  result;
  fswt_pkg::result_t  res_out;

  assign item_stall = full;
  assign take       = item_valid && !full;

  fswt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .take       (take),
    .action     (action),
    .data_byte  (data_byte),
    .link_ready (link_ready),
    .shift_byte (shift_byte),
    .mem_req    (mem_req),
    .result     (result)
  );

  fswt_frame_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (shift_byte)
  );

  fswt_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res_in    (result),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_out   (res_out)
  );

  assign line_level = res_out.line_level;
  assign accepted   = res_out.accepted;
  assign busy_res   = res_out.busy_res;

endmodule

`default_nettype wire
